### src/wmjc_pkg.sv
// ----------------------------------------------------------------------------
// wmjc_pkg
// Shared widths, constants and types for the windowed minimum jump cost block.
// ----------------------------------------------------------------------------
package wmjc_pkg;

  localparam int DEFAULT_MAX_WINDOW = 128;

  localparam int HEIGHT_W = 16;
  localparam int COST_W   = 32;
  localparam int WIN_W    = 8;

  localparam logic [COST_W-1:0] COST_TOP = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

### src/wmjc_ifs.sv
// ----------------------------------------------------------------------------
// wmjc channel interfaces
// Valid/ready channels for input items, results and the window register.
// ----------------------------------------------------------------------------

// Input item channel: one height per transaction
interface wmjc_item_if
  import wmjc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  logic                first;

  modport source (output valid, output height, output first, input ready);
  modport sink   (input valid, input height, input first, output ready);
endinterface

// Result channel: one cost per transaction
interface wmjc_result_if
  import wmjc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] min_cost;
  logic              saturated;

  modport source (output valid, output min_cost, output saturated, input ready);
  modport sink   (input valid, input min_cost, input saturated, output ready);
endinterface

// Configuration channel: writes the jump window register
interface wmjc_cfg_if
  import wmjc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] jump_window;

  modport source (output valid, output jump_window, input ready);
  modport sink   (input valid, input jump_window, output ready);
endinterface

### src/windowed_min_jump_cost.sv
// ----------------------------------------------------------------------------
// windowed_min_jump_cost
// Forward-pass frog jump cost with a bounded jump window. Heights and costs
// of recent elements live in one ring memory; each element scans back over
// up to the window of earlier entries and keeps the running minimum.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Payload                      Transaction
//  items     in    height[15:0], first          valid && ready
//  results   out   min_cost[31:0], saturated    valid && ready
//  cfg       in    jump_window[7:0]             valid && ready (always ready)
//
//  An item scans back over reach = min(window, earlier elements in the
//  sequence) ring entries; a first element skips the scan. The ring memory
//  read port, one entry per cycle, sets the scan length.
//  Reset clears the write pointer, counts and the window (to 1); the ring needs no clear.
//  A stalled results channel holds the finished item; the next item is
//  accepted once the pending result has moved into the output register.
//
module windowed_min_jump_cost
  import wmjc_pkg::*;
#(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
  input  logic                 clk,
  input  logic                 rst,
  wmjc_item_if.sink            items,
  wmjc_result_if.source        results,
  wmjc_cfg_if.sink             cfg
);

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int ENT_W = HEIGHT_W + COST_W;
  localparam int BST_W = COST_W + 1;

  // Ring memory: {height, cost}
  logic [ENT_W-1:0] ring [MAX_WINDOW];

  state_t              state, state_next;
  logic [WIN_W-1:0]    jump_window;
  logic [HEIGHT_W-1:0] h_cur;
  logic [CNT_W-1:0]    items_seen, items_seen_next;
  logic [CNT_W-1:0]    remaining, remaining_next;
  logic [PTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic                rd_vld;
  logic                rd_en;
  logic [ENT_W-1:0]    rd_data;
  logic [BST_W-1:0]    best, best_next;
  logic                mem_we;
  logic                load_out;
  logic                out_valid;
  logic [COST_W-1:0]   out_cost;
  logic                out_sat;

  logic                item_acc;
  logic [CNT_W-1:0]    seen_start;
  logic [CMP_W-1:0]    win_eff;
  logic [CMP_W-1:0]    reach;
  logic [HEIGHT_W-1:0] diff;
  logic [BST_W-1:0]    cand;
  logic [COST_W-1:0]   res_cost;

  // Pointer decrement with wrap at the ring depth
  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) begin
      r = PTR_W'(MAX_WINDOW - 1);
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

  assign items.ready   = (state == ST_IDLE);
  assign item_acc      = items.valid && items.ready;
  assign cfg.ready     = 1'b1;
  assign results.valid     = out_valid;
  assign results.min_cost  = out_cost;
  assign results.saturated = out_sat;

  // Effective window and scan reach for the arriving item
  always_comb begin
    win_eff = CMP_W'(jump_window);
    if (win_eff == '0) begin
      win_eff = CMP_W'(1);
    end
    if (win_eff > CMP_W'(MAX_WINDOW)) begin
      win_eff = CMP_W'(MAX_WINDOW);
    end
    seen_start = items.first ? '0 : items_seen;
    reach = (CMP_W'(seen_start) < win_eff) ? CMP_W'(seen_start) : win_eff;
  end

  // Candidate from the registered ring entry
  always_comb begin
    logic [HEIGHT_W-1:0] ph;
    ph   = rd_data[ENT_W-1:COST_W];
    diff = (h_cur >= ph) ? (h_cur - ph) : (ph - h_cur);
    cand = {1'b0, rd_data[COST_W-1:0]} + BST_W'(diff);
  end

  assign res_cost = best[COST_W] ? COST_TOP : best[COST_W-1:0];

  // Next state and control
  always_comb begin
    state_next      = state;
    items_seen_next = items_seen;
    remaining_next  = remaining;
    wr_ptr_next     = wr_ptr;
    rd_ptr_next     = rd_ptr;
    best_next       = best;
    rd_en           = 1'b0;
    mem_we          = 1'b0;
    load_out        = 1'b0;

    if (rd_vld && (cand < best)) begin
      best_next = cand;
    end

    case (state)
      ST_IDLE: begin
        if (item_acc) begin
          items_seen_next = seen_start;
          if (reach == '0) begin
            best_next  = '0;
            state_next = ST_FINISH;
          end else begin
            best_next      = '1;
            remaining_next = reach[CNT_W-1:0];
            rd_ptr_next    = ptr_dec(wr_ptr);
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (remaining != '0) begin
          rd_en          = 1'b1;
          remaining_next = remaining - 1'b1;
          rd_ptr_next    = ptr_dec(rd_ptr);
        end else if (!rd_vld) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || results.ready) begin
          mem_we   = 1'b1;
          load_out = 1'b1;
          if (items_seen != CNT_W'(MAX_WINDOW)) begin
            items_seen_next = items_seen + 1'b1;
          end
          wr_ptr_next = (wr_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : wr_ptr + 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      items_seen  <= '0;
      remaining   <= '0;
      wr_ptr      <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
      jump_window <= WIN_W'(1);
    end else begin
      state      <= state_next;
      items_seen <= items_seen_next;
      remaining  <= remaining_next;
      wr_ptr     <= wr_ptr_next;
      rd_vld     <= rd_en;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        jump_window <= cfg.jump_window;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    best   <= best_next;
    if (item_acc) begin
      h_cur <= items.height;
    end
    if (load_out) begin
      out_cost <= res_cost;
      out_sat  <= best[COST_W];
    end
  end

  // Ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_ptr] <= {h_cur, res_cost};
    end
    if (rd_en) begin
      rd_data <= ring[rd_ptr];
    end
  end

`ifndef SYNTHESIS
  // Fill count never passes the ring depth
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    items_seen <= CNT_W'(MAX_WINDOW))
    else $error("items_seen above ring depth");

  // A first element needs no scan
  a_first_no_scan: assert property (@(posedge clk) disable iff (rst)
    (item_acc && items.first) |=> (state == ST_FINISH))
    else $error("first element entered scan");

  // Read data only comes back from a scan cycle
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> ($past(state) == ST_SCAN))
    else $error("ring read outside scan");

  // Each ring write hands a result to the output register
  a_write_loads_out: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (out_valid && (state == ST_IDLE)))
    else $error("ring write without result");
`endif

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: windowed minimum jump cost testbench
// Feeds height sequences over the item channel, reprograms the jump window
// between phases and checks every cost against an in-bench forward-pass
// model or a typed directed result. Directed rows first, then random
// sequences under random idling and one long back-pressure hold.
// ----------------------------------------------------------------------------
module tb;
  import wmjc_pkg::*;

  localparam int RING           = DEFAULT_MAX_WINDOW;
  localparam int WIDE_W         = COST_W + 2;
  localparam int NO_WIN         = -1;
  localparam int RAND_WIN       = -2;
  localparam int IDLE_PCT       = 35;
  localparam int HOLD_CYCLES    = 800;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = RING + 8;
  localparam int CFG_SETTLE     = 4;
  localparam int N_DIRECTED     = 22;
  localparam int N_PHASES       = 14;
  localparam int PHASE_ITEMS    = 55;
  localparam int MAX_REPORTS    = 20;
  localparam logic [HEIGHT_W-1:0] HEIGHT_TOP = '1;

  typedef logic [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              sat;
  } cost_rec_t;

  // One directed row: optional window write, the item, optional typed result
  typedef struct packed {
    int                  win;
    logic [HEIGHT_W-1:0] height;
    logic                first;
    logic                typed;
    logic [COST_W-1:0]   cost;
    logic                sat;
  } dir_row_t;

  typedef enum int {
    HT_ANY,
    HT_NEAR,
    HT_EXTREME,
    HT_RAMP
  } height_mix_t;

  localparam int PHASE_WIN [N_PHASES] =
    '{1, 2, 3, 4, 7, 16, 33, 64, 127, 128, 129, 255, 0, RAND_WIN};

  logic clk;
  logic rst;

  wmjc_item_if   item_ch ();
  wmjc_result_if res_ch ();
  wmjc_cfg_if    cfg_ch ();

  windowed_min_jump_cost dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // Model state: ring of recent heights and costs, window register
  logic [HEIGHT_W-1:0] heights_held [RING];
  logic [COST_W-1:0]   costs_held [RING];
  int                  slot_next;
  int                  held_count;
  logic [WIN_W-1:0]    win_reg;

  cost_rec_t pending_costs [$];

  int idle_pct;
  int hold_asked;
  int n_errors;
  int n_items;
  int n_costs;
  int n_sat_seen;
  int n_cfg;
  int n_seq;
  int run_len;
  int longest_run;
  int quiet_cycles;

  dir_row_t directed_rows [N_DIRECTED] = '{
    // no start flag after reset: behaves as a first element
    '{NO_WIN, 16'd1234, 1'b0, 1'b1, 32'd0, 1'b0},
    '{NO_WIN, 16'd0,    1'b0, 1'b1, 32'd1234, 1'b0},
    '{NO_WIN, 16'hFFFF, 1'b0, 1'b1, 32'd66769, 1'b0},
    '{NO_WIN, 16'hFFFF, 1'b1, 1'b1, 32'd0, 1'b0},
    '{NO_WIN, 16'd0,    1'b0, 1'b1, 32'd65535, 1'b0},
    // zero window acts as a window of one
    '{0,      16'hFFFF, 1'b0, 1'b1, 32'd131070, 1'b0},
    '{NO_WIN, 16'hFFFF, 1'b0, 1'b1, 32'd131070, 1'b0},
    '{3,      16'd10,   1'b1, 1'b1, 32'd0, 1'b0},
    '{NO_WIN, 16'd20,   1'b0, 1'b0, 32'd0, 1'b0},
    '{NO_WIN, 16'd5,    1'b0, 1'b0, 32'd0, 1'b0},
    '{NO_WIN, 16'd30,   1'b0, 1'b0, 32'd0, 1'b0},
    '{NO_WIN, 16'h5555, 1'b0, 1'b0, 32'd0, 1'b0},
    // window above the ring depth is capped
    '{255,    16'hAAAA, 1'b1, 1'b1, 32'd0, 1'b0},
    '{NO_WIN, 16'h5555, 1'b0, 1'b1, 32'd21845, 1'b0},
    '{NO_WIN, 16'hAAAA, 1'b0, 1'b1, 32'd0, 1'b0},
    '{NO_WIN, 16'h0000, 1'b0, 1'b0, 32'd0, 1'b0},
    // window changed inside a sequence
    '{2,      16'h1000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{1,      16'h1000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{128,    16'hFFFF, 1'b1, 1'b1, 32'd0, 1'b0},
    '{NO_WIN, 16'h0000, 1'b0, 1'b1, 32'd65535, 1'b0},
    '{NO_WIN, 16'hFFFF, 1'b0, 1'b1, 32'd0, 1'b0},
    '{NO_WIN, 16'h8000, 1'b0, 1'b0, 32'd0, 1'b0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Forward-pass cost of one element; updates the model rings
  function automatic cost_rec_t min_jump_cost(input logic [HEIGHT_W-1:0] h,
                                              input logic start);
    cost_rec_t           r;
    wide_t               best;
    wide_t               cand;
    logic [HEIGHT_W-1:0] diff;
    int                  reach;
    int                  slot;
    if (start) held_count = 0;
    best = '0;
    if (held_count != 0) begin
      reach = (win_reg == 0) ? 1 : ((win_reg > RING) ? RING : int'(win_reg));
      if (reach > held_count) reach = held_count;
      best = '1;
      for (int j = 1; j <= reach; j++) begin
        slot = (slot_next + RING - j) % RING;
        diff = (h >= heights_held[slot]) ? h - heights_held[slot] : heights_held[slot] - h;
        cand = wide_t'(costs_held[slot]) + wide_t'(diff);
        if (cand < best) best = cand;
      end
    end
    r.sat  = (best > wide_t'(COST_TOP));
    r.cost = r.sat ? COST_TOP : best[COST_W-1:0];
    heights_held[slot_next] = h;
    costs_held[slot_next]   = r.cost;
    slot_next = (slot_next + 1) % RING;
    if (held_count < RING) held_count++;
    return r;
  endfunction

  task automatic note_cost_error(input string what, input logic [COST_W-1:0] got,
                                 input logic [COST_W-1:0] want);
    if (n_errors < MAX_REPORTS)
      $display("ERROR cost %0d %s: got %0h want %0h", n_costs, what, got, want);
    n_errors++;
  endtask

  // Offer one height; record the expected cost once the transaction is taken
  task automatic send_height(input logic [HEIGHT_W-1:0] h, input logic start,
                             input logic typed, input cost_rec_t want);
    cost_rec_t p;
    if ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item_ch.valid  <= 1'b1;
    item_ch.height <= h;
    item_ch.first  <= start;
    do @(posedge clk); while (!item_ch.ready);
    p = min_jump_cost(h, start);
    pending_costs = {pending_costs, (typed ? want : p)};
    n_items++;
    if (start || run_len == 0) begin
      n_seq++;
      run_len = 1;
    end else begin
      run_len++;
    end
    if (run_len > longest_run) longest_run = run_len;
  endtask

  // Window write, only once the block has drained
  task automatic write_window(input logic [WIN_W-1:0] w);
    item_ch.valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.jump_window <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    win_reg = w;
    n_cfg++;
  endtask

  // Random sequences: mostly well formed, some continuing without a start
  task automatic run_phase(input int budget);
    int                  left;
    int                  len;
    int                  r;
    height_mix_t         mix;
    logic [HEIGHT_W-1:0] base;
    logic [HEIGHT_W-1:0] h;
    logic                opened;
    left = budget;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(1, 24);
      else if (r < 92) len = $urandom_range(25, 60);
      else len = $urandom_range(RING + 1, RING + 42);
      mix    = height_mix_t'($urandom_range(3));
      base   = HEIGHT_W'($urandom);
      opened = ($urandom_range(99) >= 8);
      for (int k = 0; k < len; k++) begin
        case (mix)
          HT_ANY:     h = HEIGHT_W'($urandom);
          HT_NEAR:    h = HEIGHT_W'(base + $urandom_range(15));
          HT_EXTREME: h = $urandom_range(1) ? HEIGHT_TOP : '0;
          default: begin
            h    = base;
            base = HEIGHT_W'(base + $urandom_range(2000));
          end
        endcase
        send_height(h, (k == 0) ? opened : ($urandom_range(199) == 0), 1'b0, '0);
      end
      left -= len;
    end
  endtask

  // Result side: random ready, long hold on request, compare with the model
  initial begin
    cost_rec_t want;
    int        hold_seen;
    int        hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_costs.size() == 0) begin
          note_cost_error("unexpected transaction", res_ch.min_cost, '0);
        end else begin
          want = pending_costs.pop_front();
          if (res_ch.min_cost !== want.cost)
            note_cost_error("min_cost", res_ch.min_cost, want.cost);
          if (res_ch.saturated !== want.sat)
            note_cost_error("saturated", COST_W'(res_ch.saturated), COST_W'(want.sat));
        end
        if (res_ch.saturated === 1'b1) n_sat_seen++;
        n_costs++;
      end
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
      if (hold_left > 0) hold_left--;
      @(posedge clk);
    end
  end

  // Watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    cost_rec_t want;
    int        w;
    idle_pct     = IDLE_PCT;
    hold_asked   = 0;
    n_errors     = 0;
    n_items      = 0;
    n_costs      = 0;
    n_sat_seen   = 0;
    n_cfg        = 0;
    n_seq        = 0;
    run_len      = 0;
    longest_run  = 0;
    slot_next    = 0;
    held_count   = 0;
    win_reg      = 8'd1;
    item_ch.valid      <= 1'b0;
    item_ch.height     <= '0;
    item_ch.first      <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.jump_window <= '0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].win != NO_WIN) begin
        write_window(WIN_W'(directed_rows[i].win));
        run_len = (directed_rows[i].first) ? 0 : run_len;
      end
      want.cost = directed_rows[i].cost;
      want.sat  = directed_rows[i].sat;
      send_height(directed_rows[i].height, directed_rows[i].first,
                  directed_rows[i].typed, want);
    end

    // Random phases, one window setting each
    for (int p = 0; p < N_PHASES; p++) begin
      w = (PHASE_WIN[p] == RAND_WIN) ? $urandom_range(255) : PHASE_WIN[p];
      write_window(WIN_W'(w));
      idle_pct = (p == 5) ? 0 : IDLE_PCT;
      // long results hold while items keep coming: fills the block
      if (p == 2) hold_asked++;
      run_phase(PHASE_ITEMS);
    end

    // Window change with the sequence still open
    write_window(8'd3);
    idle_pct = IDLE_PCT;
    for (int n = 0; n < 12; n++) send_height(HEIGHT_W'($urandom), 1'b0, 1'b0, '0);

    // Drain
    item_ch.valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d heights in %0d sequences (longest %0d), %0d window writes",
             n_items, n_seq, longest_run, n_cfg);
    $display("run: %0d costs compared, %0d flagged saturated, %0d mismatches",
             n_costs, n_sat_seen, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
